// File: design/spp_pkg.sv
package spp_pkg;

  // parse phases; phases at or above PH_FIELD select a field slot (phase - PH_FIELD)
  localparam logic [5:0] PH_ID    = 6'd0;
  localparam logic [5:0] PH_LEN   = 6'd1;
  localparam logic [5:0] PH_SKIP  = 6'd2;
  localparam logic [5:0] PH_FIELD = 6'd3;

  localparam logic [5:0] NUM_CODES       = 6'd41;
  localparam logic [5:0] CODE_GYRO_COUNT = 6'd29;
  localparam logic [5:0] CODE_GYRO_X     = 6'd30;
  localparam logic [5:0] CODE_GYRO_Z     = 6'd32;
  localparam logic [5:0] PH_GYRO_X       = PH_FIELD + CODE_GYRO_X;

  localparam logic [7:0] ID_RAW_GYRO = 8'h0D;

  localparam logic [3:0] ST_OK    = 4'd0;
  localparam logic [3:0] ST_CSUM  = 4'd1;
  localparam logic [3:0] ST_TRUNC = 4'd12;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       packet_start;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  field_code;
    logic [31:0] field_value;
    logic [6:0]  sample_index;
    logic        is_status;
    logic [3:0]  status_code;
  } res_t;

  typedef struct packed {
    logic       known;
    logic [5:0] start;
    logic [7:0] len;
    logic [3:0] err;
  } id_info_t;

  typedef struct packed {
    logic [2:0]  size;
    logic        last;
    logic [2:0]  tail;
    logic [31:0] mask;
  } slot_t;

  function automatic id_info_t lookup_id(input logic [7:0] id);
    id_info_t r;
    r = '0;
    case (id)
      8'h01: r = '{1'b1, 6'd0,  8'h0F, 4'd2};
      8'h03: r = '{1'b1, 6'd12, 8'h03, 4'd3};
      8'h04: r = '{1'b1, 6'd15, 8'h07, 4'd4};
      8'h05: r = '{1'b1, 6'd17, 8'h06, 4'd5};
      8'h06: r = '{1'b1, 6'd20, 8'h02, 4'd6};
      8'h0A: r = '{1'b1, 6'd22, 8'h04, 4'd7};
      8'h0B: r = '{1'b1, 6'd25, 8'h04, 4'd8};
      8'h0D: r = '{1'b1, 6'd28, 8'h00, 4'd9};
      8'h10: r = '{1'b1, 6'd33, 8'h10, 4'd10};
      8'h13: r = '{1'b1, 6'd38, 8'h0C, 4'd11};
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic slot_t slot_info(input logic [5:0] code);
    slot_t r;
    r = '{3'd1, 1'b0, 3'd0, 32'hFFFF_FFFF};
    case (code)
      6'd0, 6'd4, 6'd5, 6'd15, 6'd17, 6'd18, 6'd30, 6'd31, 6'd32,
      6'd33, 6'd34, 6'd35, 6'd36:   r.size = 3'd2;
      6'd1, 6'd3:                   r.mask = 32'h0000_0007;
      6'd2:                         r.mask = 32'h0000_0003;
      6'd11, 6'd14, 6'd21:          r.last = 1'b1;
      6'd16:                        r = '{3'd2, 1'b1, 3'd3, 32'hFFFF_FFFF};
      6'd19:                        r = '{3'd2, 1'b1, 3'd0, 32'hFFFF_FFFF};
      6'd24, 6'd27:                 r = '{3'd1, 1'b1, 3'd1, 32'hFFFF_FFFF};
      6'd37:                        r = '{3'd2, 1'b1, 3'd6, 32'hFFFF_FFFF};
      6'd38, 6'd39:                 r.size = 3'd4;
      6'd40:                        r = '{3'd4, 1'b1, 3'd0, 32'hFFFF_FFFF};
      default:                      r = '{3'd1, 1'b0, 3'd0, 32'hFFFF_FFFF};
    endcase
    return r;
  endfunction

endpackage

// File: design/spp_in_reg.sv
module spp_in_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  spp_pkg::in_item_t in_item,
  input  logic              take,
  output logic              item_vld,
  output spp_pkg::in_item_t item
);

  logic              vld_r, vld_nxt;
  spp_pkg::in_item_t item_r;

  assign in_ready = !vld_r || take;
  assign vld_nxt  = in_ready ? in_valid : vld_r;
  assign item_vld = vld_r;
  assign item     = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

endmodule

// File: design/spp_core.sv
module spp_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  spp_pkg::in_item_t item,
  output logic              res_vld,
  output spp_pkg::res_t     res
);

  logic        inpkt_r, inpkt_nxt;
  logic [7:0]  bpos_r, bpos_nxt;
  logic [7:0]  plen_r, plen_nxt;
  logic [7:0]  xor_r, xor_nxt;
  logic [5:0]  phase_r, phase_nxt;
  logic [7:0]  sid_r, sid_nxt;
  logic [7:0]  skip_r, skip_nxt;
  logic [31:0] asm_r, asm_nxt;
  logic [6:0]  gl_r, gl_nxt;
  logic [3:0]  ferr_r, ferr_nxt;
  logic [2:0]  fb_r, fb_nxt;

  logic [7:0]          b;
  logic [8:0]          pos;
  logic [7:0]          xor_new;
  spp_pkg::id_info_t   info;
  logic [5:0]          code;
  spp_pkg::slot_t      slot;
  logic [31:0]         asm_new;
  logic [2:0]          fb_new;
  logic [15:0]         prod;
  logic [6:0]          div3;
  logic [6:0]          gl_dec;
  logic [7:0]          skip_dec;
  logic                len_ok;

  always_comb begin
    b        = item.byte_value;
    pos      = {1'b0, bpos_r} + 9'd1;
    xor_new  = xor_r ^ b;
    info     = spp_pkg::lookup_id(sid_r);
    code     = phase_r - spp_pkg::PH_FIELD;
    slot     = spp_pkg::slot_info(code);
    asm_new  = asm_r | ({24'd0, b} << {fb_r[1:0], 3'b000});
    fb_new   = fb_r + 3'd1;
    prod     = {8'd0, b} * 16'd171;     // b / 3 exact for 8-bit b
    div3     = prod[15:9];
    gl_dec   = (gl_r != 7'd0) ? gl_r - 7'd1 : gl_r;
    skip_dec = (skip_r != 8'd0) ? skip_r - 8'd1 : skip_r;
    len_ok   = (sid_r == spp_pkg::ID_RAW_GYRO) ? !b[0] : (b == info.len);

    inpkt_nxt = inpkt_r;
    bpos_nxt  = bpos_r;
    plen_nxt  = plen_r;
    xor_nxt   = xor_r;
    phase_nxt = phase_r;
    sid_nxt   = sid_r;
    skip_nxt  = skip_r;
    asm_nxt   = asm_r;
    gl_nxt    = gl_r;
    ferr_nxt  = ferr_r;
    fb_nxt    = fb_r;
    res_vld   = 1'b0;
    res       = '0;

    if (fire) begin
      if (item.packet_start) begin
        inpkt_nxt = 1'b1;
        bpos_nxt  = 8'd0;
        plen_nxt  = b;
        xor_nxt   = b;
        phase_nxt = spp_pkg::PH_ID;
        sid_nxt   = 8'd0;
        skip_nxt  = 8'd0;
        asm_nxt   = 32'd0;
        gl_nxt    = 7'd0;
        ferr_nxt  = spp_pkg::ST_OK;
        fb_nxt    = 3'd0;
      end else if (inpkt_r) begin
        bpos_nxt = pos[7:0];
        xor_nxt  = xor_new;
        if (pos == {1'b0, plen_r} + 9'd1) begin
          // checksum byte: final status
          inpkt_nxt     = 1'b0;
          res_vld       = 1'b1;
          res.is_status = 1'b1;
          if (xor_new != 8'd0) begin
            res.status_code = spp_pkg::ST_CSUM;
          end else if (ferr_r != spp_pkg::ST_OK) begin
            res.status_code = ferr_r;
          end else if (phase_r != spp_pkg::PH_ID) begin
            res.status_code = spp_pkg::ST_TRUNC;
          end else begin
            res.status_code = spp_pkg::ST_OK;
          end
        end else if (ferr_r == spp_pkg::ST_OK) begin
          case (phase_r)
            spp_pkg::PH_ID: begin
              sid_nxt   = b;
              phase_nxt = spp_pkg::PH_LEN;
            end
            spp_pkg::PH_LEN: begin
              if (info.known) begin
                if (!len_ok) begin
                  ferr_nxt = info.err;
                end else begin
                  phase_nxt = spp_pkg::PH_FIELD + info.start;
                  asm_nxt   = 32'd0;
                  fb_nxt    = 3'd0;
                end
              end else begin
                skip_nxt  = b;
                phase_nxt = (b != 8'd0) ? spp_pkg::PH_SKIP : spp_pkg::PH_ID;
              end
            end
            spp_pkg::PH_SKIP: begin
              skip_nxt = skip_dec;
              if (skip_dec == 8'd0) begin
                phase_nxt = spp_pkg::PH_ID;
              end
            end
            default: begin
              if (code >= spp_pkg::NUM_CODES) begin
                phase_nxt = spp_pkg::PH_ID;
              end else if (fb_new < slot.size) begin
                asm_nxt = asm_new;
                fb_nxt  = fb_new;
              end else begin
                res_vld         = 1'b1;
                res.field_code  = code;
                res.field_value = asm_new & slot.mask;
                asm_nxt         = 32'd0;
                fb_nxt          = 3'd0;
                if (code == spp_pkg::CODE_GYRO_COUNT) begin
                  res.field_value = {25'd0, div3};
                  gl_nxt          = div3;
                  skip_nxt        = {1'b0, div3};
                  phase_nxt       = (div3 != 7'd0) ? spp_pkg::PH_GYRO_X : spp_pkg::PH_ID;
                end else if (code >= spp_pkg::CODE_GYRO_X && code <= spp_pkg::CODE_GYRO_Z) begin
                  // skip_r holds the frame total while frames are read
                  res.sample_index = skip_r[6:0] - gl_r;
                  if (code == spp_pkg::CODE_GYRO_Z) begin
                    gl_nxt    = gl_dec;
                    phase_nxt = (gl_dec != 7'd0) ? spp_pkg::PH_GYRO_X : spp_pkg::PH_ID;
                    if (gl_dec == 7'd0) begin
                      skip_nxt = 8'd0;
                    end
                  end else begin
                    phase_nxt = phase_r + 6'd1;
                  end
                end else if (slot.last) begin
                  skip_nxt  = {5'd0, slot.tail};
                  phase_nxt = (slot.tail != 3'd0) ? spp_pkg::PH_SKIP : spp_pkg::PH_ID;
                end else begin
                  phase_nxt = phase_r + 6'd1;
                end
              end
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inpkt_r <= 1'b0;
      bpos_r  <= 8'd0;
      plen_r  <= 8'd0;
      xor_r   <= 8'd0;
      phase_r <= spp_pkg::PH_ID;
      sid_r   <= 8'd0;
      skip_r  <= 8'd0;
      asm_r   <= 32'd0;
      gl_r    <= 7'd0;
      ferr_r  <= spp_pkg::ST_OK;
      fb_r    <= 3'd0;
    end else begin
      inpkt_r <= inpkt_nxt;
      bpos_r  <= bpos_nxt;
      plen_r  <= plen_nxt;
      xor_r   <= xor_nxt;
      phase_r <= phase_nxt;
      sid_r   <= sid_nxt;
      skip_r  <= skip_nxt;
      asm_r   <= asm_nxt;
      gl_r    <= gl_nxt;
      ferr_r  <= ferr_nxt;
      fb_r    <= fb_nxt;
    end
  end

endmodule

// File: design/spp_out_buf.sv
module spp_out_buf (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  spp_pkg::res_t push_res,
  output logic          space,
  output logic          out_valid,
  input  logic          out_ready,
  output spp_pkg::res_t out_res
);

  spp_pkg::res_t mem_r [2];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    cnt_r, cnt_nxt;
  logic          pop;

  assign out_valid  = (cnt_r != 2'd0);
  assign out_res    = mem_r[rd_ptr_r];
  assign pop        = out_valid && out_ready;
  // a full buffer still takes a result when the head leaves this cycle
  assign space      = (cnt_r != 2'd2) || out_ready;
  assign wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
  assign rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
  assign cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_res;
    end
  end

endmodule

// File: design/sensor_packet_subpayload_parser.sv
// Chan  Handshake            Fields (port name = prefix + field)
// in    in_valid/in_ready    in_:  byte_value packet_start
// out   out_valid/out_ready  out_: field_code field_value sample_index is_status status_code
//
// Each in transfer is one packet byte; each out transfer one field or the packet status.
// One byte per cycle while the result buffer has room: each byte is a single pass through the
// parser logic between the input register and the two-entry result buffer.
// Each result is built from the registered byte and shows on out_* from the result buffer.
// Synchronous active-low reset clears the parser state, empties both stages.
// A stalled out channel backs up only once two results are waiting.
module sensor_packet_subpayload_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte_value,
  input  logic        in_packet_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  out_field_code,
  output logic [31:0] out_field_value,
  output logic [6:0]  out_sample_index,
  output logic        out_is_status,
  output logic [3:0]  out_status_code
);

  spp_pkg::in_item_t in_item;
  spp_pkg::in_item_t item;
  logic              item_vld;
  logic              space;
  logic              fire;
  logic              res_vld;
  spp_pkg::res_t     res;
  spp_pkg::res_t     out_res;

  assign in_item.byte_value   = in_byte_value;
  assign in_item.packet_start = in_packet_start;

  // registered byte is parsed whenever the result buffer can take a transfer
  assign fire = item_vld && space;

  spp_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .take     (fire),
    .item_vld (item_vld),
    .item     (item)
  );

  // packet framing, XOR check, sub-payload walk and field assembly
  spp_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .item    (item),
    .res_vld (res_vld),
    .res     (res)
  );

  spp_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fire && res_vld),
    .push_res  (res),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_field_code   = out_res.field_code;
  assign out_field_value  = out_res.field_value;
  assign out_sample_index = out_res.sample_index;
  assign out_is_status    = out_res.is_status;
  assign out_status_code  = out_res.status_code;

endmodule

// File: bench/subpayload_check_pkg.sv
package subpayload_check_pkg;

  import spp_pkg::*;

  // sub-payload ids with a fixed layout
  localparam logic [7:0] ID_CORE      = 8'h01;
  localparam logic [7:0] ID_IR        = 8'h03;
  localparam logic [7:0] ID_INERTIAL  = 8'h04;
  localparam logic [7:0] ID_CLIFF_ADC = 8'h05;
  localparam logic [7:0] ID_CURRENT   = 8'h06;
  localparam logic [7:0] ID_HW_VER    = 8'h0A;
  localparam logic [7:0] ID_FW_VER    = 8'h0B;
  localparam logic [7:0] ID_GPIO      = 8'h10;
  localparam logic [7:0] ID_UDID      = 8'h13;
  // an id the parser does not know, skipped by its length byte
  localparam logic [7:0] ID_PAD       = 8'hEE;

  // length error status per sub-payload
  localparam logic [3:0] ST_LEN_CORE      = 4'd2;
  localparam logic [3:0] ST_LEN_IR        = 4'd3;
  localparam logic [3:0] ST_LEN_INERTIAL  = 4'd4;
  localparam logic [3:0] ST_LEN_CLIFF_ADC = 4'd5;
  localparam logic [3:0] ST_LEN_CURRENT   = 4'd6;
  localparam logic [3:0] ST_LEN_HW_VER    = 4'd7;
  localparam logic [3:0] ST_LEN_FW_VER    = 4'd8;
  localparam logic [3:0] ST_LEN_GYRO      = 4'd9;
  localparam logic [3:0] ST_LEN_GPIO      = 4'd10;
  localparam logic [3:0] ST_LEN_UDID      = 4'd11;

  // flag fields that come out masked
  localparam int CODE_BUMPER     = 1;
  localparam int CODE_WHEEL_DROP = 2;
  localparam int CODE_CLIFF      = 3;

  // first field code, required length and length error of a known id
  function automatic bit sub_layout(input logic [7:0] id, output logic [5:0] first_code,
                                    output logic [7:0] body_len, output logic [3:0] len_err);
    bit known;
    known      = 1'b1;
    first_code = '0;
    body_len   = '0;
    len_err    = ST_OK;
    case (id)
      ID_CORE: begin
        first_code = 6'd0;  body_len = 8'h0F; len_err = ST_LEN_CORE;
      end
      ID_IR: begin
        first_code = 6'd12; body_len = 8'h03; len_err = ST_LEN_IR;
      end
      ID_INERTIAL: begin
        first_code = 6'd15; body_len = 8'h07; len_err = ST_LEN_INERTIAL;
      end
      ID_CLIFF_ADC: begin
        first_code = 6'd17; body_len = 8'h06; len_err = ST_LEN_CLIFF_ADC;
      end
      ID_CURRENT: begin
        first_code = 6'd20; body_len = 8'h02; len_err = ST_LEN_CURRENT;
      end
      ID_HW_VER: begin
        first_code = 6'd22; body_len = 8'h04; len_err = ST_LEN_HW_VER;
      end
      ID_FW_VER: begin
        first_code = 6'd25; body_len = 8'h04; len_err = ST_LEN_FW_VER;
      end
      ID_RAW_GYRO: begin
        first_code = 6'd28; body_len = 8'h00; len_err = ST_LEN_GYRO;
      end
      ID_GPIO: begin
        first_code = 6'd33; body_len = 8'h10; len_err = ST_LEN_GPIO;
      end
      ID_UDID: begin
        first_code = 6'd38; body_len = 8'h0C; len_err = ST_LEN_UDID;
      end
      default: known = 1'b0;
    endcase
    return known;
  endfunction

  class packet_field_tracker;
    res_t        fields_due[$];
    int          errors;

    logic [7:0]  pos;
    logic [7:0]  pkt_len;
    logic [7:0]  xsum;
    logic [5:0]  phase;
    logic [7:0]  sub_id;
    logic [7:0]  skip_left;   // also keeps the gyro frame total
    logic [31:0] assembly;
    logic [6:0]  frames_left;
    logic [3:0]  first_err;
    int          bytes_in;
    bit          open;

    function new();
      errors = 0;
      open   = 1'b0;
      restart();
    endfunction

    function void restart();
      pos         = '0;
      pkt_len     = '0;
      xsum        = '0;
      phase       = PH_ID;
      sub_id      = '0;
      skip_left   = '0;
      assembly    = '0;
      frames_left = '0;
      first_err   = ST_OK;
      bytes_in    = 0;
    endfunction

    // advance the parse by one accepted byte, queue the result it causes
    function void decode_byte(logic [7:0] b, logic start);
      res_t        r;
      int unsigned nxt;
      int unsigned code;
      int          width;
      int          tail;
      logic [5:0]  first_code;
      logic [7:0]  body_len;
      logic [3:0]  len_err;
      logic [7:0]  span;
      logic [31:0] value;
      r = '0;
      if (start) begin
        restart();
        pkt_len = b;
        xsum    = b;
        open    = 1'b1;
        return;
      end
      if (!open) return;

      nxt  = 32'(pos) + 1;
      pos  = 8'(nxt);
      xsum = xsum ^ b;
      if (nxt == 32'(pkt_len) + 1) begin
        r.is_status = 1'b1;
        if (xsum != 8'h00) r.status_code = ST_CSUM;
        else if (first_err != ST_OK) r.status_code = first_err;
        else if (phase != PH_ID) r.status_code = ST_TRUNC;
        else r.status_code = ST_OK;
        open = 1'b0;
        fields_due = {fields_due, r};
        return;
      end
      if (first_err != ST_OK) return;

      if (phase == PH_ID) begin
        sub_id = b;
        phase  = PH_LEN;
        return;
      end
      if (phase == PH_LEN) begin
        if (sub_layout(sub_id, first_code, body_len, len_err)) begin
          if ((sub_id == ID_RAW_GYRO) ? b[0] : (b != body_len)) begin
            first_err = len_err;
            return;
          end
          phase    = PH_FIELD + first_code;
          assembly = '0;
          bytes_in = 0;
        end else begin
          skip_left = b;
          phase     = (b != 8'h00) ? PH_SKIP : PH_ID;
        end
        return;
      end
      if (phase == PH_SKIP) begin
        if (skip_left != 0) skip_left--;
        if (skip_left == 0) phase = PH_ID;
        return;
      end

      code = 32'(phase) - 32'(PH_FIELD);
      if (code >= NUM_CODES) begin
        phase = PH_ID;
        return;
      end
      assembly = assembly | (32'(b) << (8 * (bytes_in % 4)));
      bytes_in++;
      case (code)
        0, 4, 5, 15, 16, 17, 18, 19, 30, 31, 32, 33, 34, 35, 36, 37: width = 2;
        38, 39, 40: width = 4;
        default: width = 1;
      endcase
      if (bytes_in < width) return;

      value = assembly;
      if (code == CODE_BUMPER || code == CODE_CLIFF) value = value & 32'h7;
      else if (code == CODE_WHEEL_DROP) value = value & 32'h3;
      assembly = '0;
      bytes_in = 0;

      if (code == CODE_GYRO_COUNT) begin
        value       = 32'(b / 8'd3);
        frames_left = 7'(value);
        skip_left   = 8'(value);
        phase       = (value != 0) ? PH_GYRO_X : PH_ID;
      end else if (code >= CODE_GYRO_X && code <= CODE_GYRO_Z) begin
        span           = skip_left - {1'b0, frames_left};
        r.sample_index = span[6:0];
        if (code == CODE_GYRO_Z) begin
          if (frames_left != 0) frames_left--;
          phase = (frames_left != 0) ? PH_GYRO_X : PH_ID;
          if (frames_left == 0) skip_left = '0;
        end else begin
          phase = phase + 1'b1;
        end
      end else begin
        // last field of a sub-payload: reserved bytes that follow it, or none
        case (code)
          11, 14, 19, 21, 40: tail = 0;
          16: tail = 3;
          24, 27: tail = 1;
          37: tail = 6;
          default: tail = -1;
        endcase
        if (tail < 0) begin
          phase = phase + 1'b1;
        end else begin
          skip_left = 8'(tail);
          phase     = (tail != 0) ? PH_SKIP : PH_ID;
        end
      end
      r.field_code  = 6'(code);
      r.field_value = value;
      fields_due = {fields_due, r};
    endfunction

    function string show(res_t r);
      return $sformatf("code=%0d value=%h index=%0d status=%0b/%0d", r.field_code,
                       r.field_value, r.sample_index, r.is_status, r.status_code);
    endfunction

    task report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    task match_result(res_t got);
      res_t want;
      if (fields_due.size() == 0) begin
        report($sformatf("result with nothing pending: %s", show(got)));
        return;
      end
      want = fields_due.pop_front();
      if (got.field_code !== want.field_code || got.field_value !== want.field_value ||
          got.sample_index !== want.sample_index || got.is_status !== want.is_status ||
          got.status_code !== want.status_code)
        report($sformatf("got %s, want %s", show(got), show(want)));
    endtask
  endclass

endpackage

// File: bench/sensor_packet_subpayload_parser_test.sv
module sensor_packet_subpayload_parser_test;
  timeunit 1ns;
  timeprecision 1ps;

  import spp_pkg::*;
  import subpayload_check_pkg::*;

  // bytes that reach the parser; noise outside a packet does not count
  localparam int PARSE_BYTES = 1300;
  // long receiver hold-off, started once enough bytes went in
  localparam int HOLD_OFF    = 500;
  localparam int HOLD_AFTER  = 400;
  localparam int LIMIT       = 200000;

  typedef enum {FILL_RANDOM, FILL_ZERO, FILL_ONES, FILL_MIXED} fill_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_byte_value;
  logic        in_packet_start;
  logic        out_valid;
  logic        out_ready;
  logic [5:0]  out_field_code;
  logic [31:0] out_field_value;
  logic [6:0]  out_sample_index;
  logic        out_is_status;
  logic [3:0]  out_status_code;

  packet_field_tracker tracker;
  in_item_t            byte_stream[$];   // every byte to send, in order
  logic [7:0]          pkt_body[$];      // payload of the packet being built
  int                  parse_bytes;
  int                  accepted;
  int                  cycles;

  sensor_packet_subpayload_parser dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_byte_value    (in_byte_value),
    .in_packet_start  (in_packet_start),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_field_code   (out_field_code),
    .out_field_value  (out_field_value),
    .out_sample_index (out_sample_index),
    .out_is_status    (out_is_status),
    .out_status_code  (out_status_code)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic void push_byte(logic [7:0] b, logic s, bit counted);
    in_item_t it;
    it.byte_value   = b;
    it.packet_start = s;
    byte_stream = {byte_stream, it};
    if (counted) parse_bytes++;
  endfunction

  // content byte; whole packets of 0x00 or 0xFF hit the field extremes and masks
  function automatic logic [7:0] body_byte(fill_t fill);
    case (fill)
      FILL_ZERO: return 8'h00;
      FILL_ONES: return 8'hFF;
      FILL_MIXED: begin
        case ($urandom_range(0, 2))
          0: return 8'h00;
          1: return 8'hFF;
          default: return 8'($urandom);
        endcase
      end
      default: return 8'($urandom);
    endcase
  endfunction

  // one sub-payload onto pkt_body; bad_len spoils its length byte
  function automatic void append_sub(fill_t fill, bit bad_len);
    logic [7:0] id;
    logic [7:0] len;
    logic [7:0] follow;
    logic [5:0] first_code;
    logic [7:0] body_len;
    logic [3:0] len_err;
    int         frames;
    if (!bad_len && $urandom_range(0, 4) == 0) begin
      // unknown id, skipped by its length byte (zero length included)
      do id = 8'($urandom); while (sub_layout(id, first_code, body_len, len_err));
      len = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(1, 10));
      pkt_body = {pkt_body, id};
      pkt_body = {pkt_body, len};
      repeat (len) pkt_body = {pkt_body, body_byte(fill)};
      return;
    end
    case ($urandom_range(0, 9))
      0: id = ID_CORE;
      1: id = ID_IR;
      2: id = ID_INERTIAL;
      3: id = ID_CLIFF_ADC;
      4: id = ID_CURRENT;
      5: id = ID_HW_VER;
      6: id = ID_FW_VER;
      7: id = ID_GPIO;
      8: id = ID_UDID;
      default: id = ID_RAW_GYRO;
    endcase
    void'(sub_layout(id, first_code, body_len, len_err));
    if (id == ID_RAW_GYRO) begin
      // frame count is the follower byte / 3; the remainder must not matter
      frames = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 40) : $urandom_range(0, 3);
      follow = 8'(3 * frames + $urandom_range(0, 2));
      len    = 8'(2 + 6 * frames);
      if ($urandom_range(0, 15) == 0) begin
        // more frames than a packet can carry: the packet ends mid-frame
        follow = 8'($urandom_range(150, 255));
        frames = follow / 3;
      end
      if (bad_len) len[0] = 1'b1;
      pkt_body = {pkt_body, id};
      pkt_body = {pkt_body, len};
      pkt_body = {pkt_body, body_byte(fill)};
      pkt_body = {pkt_body, follow};
      repeat (6 * frames) if (pkt_body.size() < 255) pkt_body = {pkt_body, body_byte(fill)};
    end else begin
      len = bad_len ? (body_len ^ 8'($urandom_range(1, 255))) : body_len;
      pkt_body = {pkt_body, id};
      pkt_body = {pkt_body, len};
      repeat (bad_len ? $urandom_range(0, 4) : int'(body_len))
        pkt_body = {pkt_body, body_byte(fill)};
    end
  endfunction

  // length byte, first len bytes of pkt_body, checksum (flip != 0 corrupts it)
  function automatic void emit_packet(logic [7:0] len, logic [7:0] flip);
    logic [7:0] check;
    int         i;
    check = len;
    push_byte(len, 1'b1, 1'b1);
    for (i = 0; i < len; i++) begin
      push_byte(pkt_body[i], 1'b0, 1'b1);
      check = check ^ pkt_body[i];
    end
    push_byte(check ^ flip, 1'b0, 1'b1);
  endfunction

  // Packet mix: mostly well-formed with random content; the rest carry a bad
  // checksum, a bad length byte, a short length, an early restart, or fill the
  // largest length; some are followed by stray bytes outside any packet.
  function automatic void random_packet();
    int         kind;
    int         nsub;
    int         err_at;
    int         cut;
    int         i;
    fill_t      fill;
    logic [7:0] len;
    kind = $urandom_range(0, 99);
    case ($urandom_range(0, 7))
      0: fill = FILL_ZERO;
      1: fill = FILL_ONES;
      2: fill = FILL_MIXED;
      default: fill = FILL_RANDOM;
    endcase
    nsub   = $urandom_range(1, 4);
    err_at = (kind >= 60 && kind < 72) ? $urandom_range(0, nsub - 1) : -1;
    pkt_body.delete();
    for (i = 0; i < nsub; i++)
      if (pkt_body.size() < 200) append_sub(fill, i == err_at);

    if (kind >= 90 && kind < 95) begin
      // pad out to a 255-byte payload with skipped sub-payloads
      while (pkt_body.size() < 255) begin
        if (255 - pkt_body.size() >= 2) begin
          cut = 253 - pkt_body.size();
          pkt_body = {pkt_body, ID_PAD};
          pkt_body = {pkt_body, 8'(cut)};
          repeat (cut) pkt_body = {pkt_body, body_byte(fill)};
        end else begin
          pkt_body = {pkt_body, body_byte(fill)};
        end
      end
    end

    len = 8'(pkt_body.size());
    if (kind >= 72 && kind < 84 && len != 0) len = 8'($urandom_range(0, len - 1));

    if (kind >= 84 && kind < 90) begin
      // next length byte arrives before this packet is complete
      push_byte(len, 1'b1, 1'b1);
      cut = $urandom_range(0, len);
      for (i = 0; i < cut; i++) push_byte(pkt_body[i], 1'b0, 1'b1);
      return;
    end

    emit_packet(len, (kind >= 48 && kind < 60) ? 8'($urandom_range(1, 255)) : 8'h00);
    if (kind >= 95)
      repeat ($urandom_range(1, 3)) push_byte(8'($urandom), 1'b0, 1'b0);
  endfunction

  // Sender: bursts of back-to-back transfers, random gaps in between.
  task automatic drive_stream();
    in_item_t it;
    int       burst;
    int       gap;
    burst = $urandom_range(1, 40);
    while (byte_stream.size() != 0) begin
      it = byte_stream.pop_front();
      in_valid        <= 1'b1;
      in_byte_value   <= it.byte_value;
      in_packet_start <= it.packet_start;
      do @(posedge clk); while (!in_ready);
      burst--;
      if (burst == 0) begin
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst = $urandom_range(1, 40);
      end
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    in_valid        <= 1'b0;
    in_byte_value   <= '0;
    in_packet_start <= 1'b0;
    rst_n           <= 1'b0;
    tracker     = new();
    parse_bytes = 0;

    // Directed packets first.
    // stray byte before any packet: ignored
    push_byte(8'hA5, 1'b0, 1'b0);
    // empty payload, checksum 0x00: good status
    pkt_body.delete();
    emit_packet(8'd0, 8'h00);
    // packet dropped by a new length byte
    push_byte(8'h03, 1'b1, 1'b1);
    push_byte(ID_CURRENT, 1'b0, 1'b1);
    // odd raw gyro length, then a byte after the error that only enters the checksum
    pkt_body = '{ID_RAW_GYRO, 8'h03, 8'h77};
    emit_packet(8'd3, 8'h00);
    // wrong IR length plus bad checksum: the checksum status wins
    pkt_body = '{ID_IR, 8'h05};
    emit_packet(8'd2, 8'h80);
    // unknown id with zero length
    pkt_body = '{ID_PAD, 8'h00};
    emit_packet(8'd2, 8'h00);
    // one wheel current field, then the packet ends mid sub-payload
    pkt_body = '{ID_CURRENT, 8'h02, 8'h55};
    emit_packet(8'd3, 8'h00);
    // wheel current extremes
    pkt_body = '{ID_CURRENT, 8'h02, 8'hFF, 8'h00};
    emit_packet(8'd4, 8'h00);
    push_byte(8'h5A, 1'b0, 1'b0);

    while (parse_bytes < PARSE_BYTES) random_packet();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    drive_stream();

    // drain, then a few cycles more to catch anything extra
    while (tracker.fields_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (tracker.errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  // Receiver: stretches of always-ready, coin-flip and mostly-stalled, plus
  // one long hold-off while the sender keeps offering, so the result buffer
  // fills and in_ready drops.
  initial begin
    int mode;
    int span;
    bit held;
    out_ready <= 1'b0;
    held = 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      mode = $urandom_range(0, 2);
      span = $urandom_range(10, 150);
      repeat (span) begin
        if (!held && accepted >= HOLD_AFTER) begin
          held = 1'b1;
          out_ready <= 1'b0;
          repeat (HOLD_OFF) @(posedge clk);
        end
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // Both channels are sampled at the edge, before any driver update lands.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        tracker.decode_byte(in_byte_value, in_packet_start);
        accepted++;
      end
      if (out_valid && out_ready)
        tracker.match_result(res_t'{out_field_code, out_field_value, out_sample_index,
                                    out_is_status, out_status_code});
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

endmodule
